// File: sv/affx_pkg.sv
// ----------------------------------------------------------------------------
// Affine transform engine package
// Shared types, kind codes, angle constants and CORDIC tables.
// ----------------------------------------------------------------------------
package affx_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned QDEPTH           = 2;

  localparam logic [2:0] KIND_IDENT = 3'd0;
  localparam logic [2:0] KIND_TRANS = 3'd1;
  localparam logic [2:0] KIND_SCALE = 3'd2;
  localparam logic [2:0] KIND_ROT   = 3'd3;
  localparam logic [2:0] KIND_VERT  = 3'd4;

  localparam longint FULL_DEG    = 64'sd360 <<< 24;
  localparam longint HALF_DEG    = 64'sd180 <<< 24;
  localparam longint QUARTER_DEG = 64'sd90 <<< 24;

  typedef enum logic [2:0] {
    OP_IDENT,
    OP_TRANS,
    OP_SCALE,
    OP_ROT,
    OP_VERT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [25:0] ang;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd754974720;
      5'd1:    v = 32'd445687602;
      5'd2:    v = 32'd235489088;
      5'd3:    v = 32'd119537938;
      5'd4:    v = 32'd60000934;
      5'd5:    v = 32'd30029717;
      5'd6:    v = 32'd15018523;
      5'd7:    v = 32'd7509720;
      5'd8:    v = 32'd3754917;
      5'd9:    v = 32'd1877466;
      5'd10:   v = 32'd938734;
      5'd11:   v = 32'd469367;
      5'd12:   v = 32'd234684;
      5'd13:   v = 32'd117342;
      5'd14:   v = 32'd58671;
      5'd15:   v = 32'd29335;
      5'd16:   v = 32'd14668;
      5'd17:   v = 32'd7334;
      5'd18:   v = 32'd3667;
      5'd19:   v = 32'd1833;
      5'd20:   v = 32'd917;
      5'd21:   v = 32'd458;
      5'd22:   v = 32'd229;
      5'd23:   v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [33:0] cordic_x0(input int unsigned steps);
    return 34'(64'd652032875 + (64'd434688583 >> (2 * steps)));
  endfunction

endpackage

// File: sv/affine_transform_2d_engine_core.sv
// ----------------------------------------------------------------------------
// 2D affine transform engine
// Composite 3x3 homogeneous transform with command and vertex items.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one item per beat. Kind
// identity, translate, scale or rotate updates the held matrix and returns
// nothing; kind vertex returns one beat on out_valid_o / out_stall_i with
// the mapped point, the clip flag and the last marker. Unused kinds drop.
// Items pass through a two-entry queue into a sequencer built around one
// 33x33 multiplier. The sequencer takes one item at a time; each matrix
// entry or output coordinate takes two product steps and a round/saturate
// step. Identity resets the matrix; translate premultiplies once; scale
// and rotate premultiply by the pivot shift, the scale or rotation and the
// shift back. Rotate first runs max(1, 17 - FRAC_BITS) angle reduction
// steps (1 at FRAC_BITS = 16) and CORDIC_STEPS CORDIC iterations.
// A result waiting under stall holds; the sequencer keeps taking commands
// and holds the next vertex at its output step. Reset sets the matrix to
// identity, clears the clip flag and empties the queue.
// ----------------------------------------------------------------------------
module affine_transform_2d_engine_core #(
  parameter int unsigned FRAC_BITS    = affx_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = affx_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic signed [31:0] pivot_x_i,
  input  logic signed [31:0] pivot_y_i,
  input  logic signed [25:0] angle_deg_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic               saturated_o,
  output logic               last_out_o
);

  affx_pkg::fq_t fq;
  logic          pop;

  affx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .pivot_x_i      (pivot_x_i),
    .pivot_y_i      (pivot_y_i),
    .angle_deg_i    (angle_deg_i),
    .last_in_i      (last_in_i),
    .fq_o           (fq),
    .pop_i          (pop)
  );

  affx_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_i        (fq),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .saturated_o (saturated_o),
    .last_out_o  (last_out_o)
  );

endmodule

// File: sv/affx_front.sv
// ----------------------------------------------------------------------------
// Affine transform engine front end
// Accepts input beats, decodes the kind and queues valid items.
// ----------------------------------------------------------------------------
module affx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic signed [31:0] pivot_x_i,
  input  logic signed [31:0] pivot_y_i,
  input  logic signed [25:0] angle_deg_i,
  input  logic               last_in_i,
  output affx_pkg::fq_t      fq_o,
  input  logic               pop_i
);

  localparam int unsigned DEPTH = affx_pkg::QDEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  affx_pkg::item_t    mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  affx_pkg::op_e      op_c;
  logic               keep_c, push_c;

  always_comb begin
    keep_c = 1'b1;
    op_c   = affx_pkg::OP_IDENT;
    unique case (kind_i)
      affx_pkg::KIND_IDENT: op_c = affx_pkg::OP_IDENT;
      affx_pkg::KIND_TRANS: op_c = affx_pkg::OP_TRANS;
      affx_pkg::KIND_SCALE: op_c = affx_pkg::OP_SCALE;
      affx_pkg::KIND_ROT:   op_c = affx_pkg::OP_ROT;
      affx_pkg::KIND_VERT:  op_c = affx_pkg::OP_VERT;
      default:              keep_c = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == CNT_W'(DEPTH));
  assign push_c     = in_valid_i && !in_stall_o && keep_c;

  assign fq_o.valid = (cnt_q != '0);
  assign fq_o.item  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_c) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_c && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_c && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_c) begin
      mem_q[wr_q] <= '{op: op_c, v1: first_value_i, v2: second_value_i,
                       px: pivot_x_i, py: pivot_y_i, ang: angle_deg_i,
                       last: last_in_i};
    end
  end

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_c && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

// File: sv/affx_back.sv
// ----------------------------------------------------------------------------
// Affine transform engine back end
// Holds the composite matrix, runs the shared multiplier, the CORDIC
// and the output register.
// ----------------------------------------------------------------------------
module affx_back #(
  parameter int unsigned FRAC_BITS    = affx_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = affx_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  affx_pkg::fq_t      fq_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic               saturated_o,
  output logic               last_out_o
);

  localparam int unsigned TW       = 33;
  localparam int unsigned PW       = 2 * TW;
  localparam int unsigned SW       = PW + 1;
  localparam int unsigned XW       = 35;
  localparam int unsigned SHIFT_IN = 24 - FRAC_BITS;
  localparam int unsigned ZW       = (28 + SHIFT_IN > 36) ? 28 + SHIFT_IN : 36;
  localparam int unsigned RED      = (25 + SHIFT_IN > 32) ? 25 + SHIFT_IN - 32 : 1;
  localparam int unsigned RW       = $clog2(RED + 1);
  localparam int unsigned SH       = 30 - FRAC_BITS;

  localparam logic signed [31:0]   ONE_M   = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [TW-1:0] ONE_T   = TW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] HALF_S  = SW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] MAX_S   = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] MIN_S   = SW'(-64'sd2147483648);
  localparam logic signed [ZW-1:0] FULL_Z  = ZW'(affx_pkg::FULL_DEG);
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(affx_pkg::HALF_DEG);
  localparam logic signed [ZW-1:0] QUART_Z = ZW'(affx_pkg::QUARTER_DEG);
  localparam logic [ZW-1:0]        FK0     = ZW'(affx_pkg::FULL_DEG << (RED - 1));
  localparam logic signed [XW-1:0] X0      = XW'(affx_pkg::cordic_x0(CORDIC_STEPS));
  localparam logic signed [XW-1:0] RND_X   = XW'(64'd1 << (SH - 1));
  localparam logic [4:0]           IT_LAST = 5'(CORDIC_STEPS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRM  = 4'd1;
  localparam logic [3:0] S_CRW  = 4'd2;
  localparam logic [3:0] S_CRF  = 4'd3;
  localparam logic [3:0] S_CRI  = 4'd4;
  localparam logic [3:0] S_CRE  = 4'd5;
  localparam logic [3:0] S_MUL0 = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] STG_PRE  = 2'd0;
  localparam logic [1:0] STG_MID  = 2'd1;
  localparam logic [1:0] STG_POST = 2'd2;

  logic [3:0]                state_q;
  affx_pkg::item_t           item_q;
  logic signed [31:0]        m_q [6];
  logic signed [31:0]        r0_q, xo_q;
  logic                      mat_clip_q, vclip_q;
  logic [1:0]                stg_q, col_q;
  logic                      row_q, vert_q;
  logic signed [PW-1:0]      prod_q, acc_q;
  logic [ZW-1:0]             zmag_q, fk_q;
  logic                      zsgn_q, neg_q;
  logic [RW-1:0]             red_q;
  logic signed [ZW-1:0]      z_q;
  logic signed [XW-1:0]      x_q, y_q;
  logic [4:0]                it_q;
  logic signed [TW-1:0]      sin_q, cos_q;
  logic                      out_valid_q, last_q, sat_q;
  logic signed [31:0]        x_out_q, y_out_q;

  logic signed [TW-1:0]      t0_c, t1_c, t2_c, mul_a_c, mul_b_c, add_c;
  logic signed [TW-1:0]      px_c, py_c, v1_c, v2_c;
  logic signed [PW-1:0]      prod_c;
  logic signed [SW-1:0]      sum_c, full_c;
  logic signed [31:0]        res_c;
  logic                      clip_c, free_c;
  logic signed [ZW-1:0]      z0_c, zt_c, atan_c;
  logic [ZW-1:0]             zmag0_c;
  logic signed [XW-1:0]      xs_c, ys_c, xf_c, yf_c;

  assign px_c = TW'(item_q.px);
  assign py_c = TW'(item_q.py);
  assign v1_c = TW'(item_q.v1);
  assign v2_c = TW'(item_q.v2);

  always_comb begin
    t0_c = '0;
    t1_c = '0;
    t2_c = '0;
    unique case (stg_q)
      STG_PRE: begin
        if (!row_q) begin
          t0_c = ONE_T;
          t2_c = -px_c;
        end else begin
          t1_c = ONE_T;
          t2_c = -py_c;
        end
      end
      STG_MID: begin
        if (item_q.op == affx_pkg::OP_ROT) begin
          t0_c = row_q ? sin_q : cos_q;
          t1_c = row_q ? cos_q : -sin_q;
        end else if (!row_q) begin
          t0_c = v1_c;
        end else begin
          t1_c = v2_c;
        end
      end
      default: begin
        if (!row_q) begin
          t0_c = ONE_T;
          t2_c = (item_q.op == affx_pkg::OP_TRANS) ? v1_c : px_c;
        end else begin
          t1_c = ONE_T;
          t2_c = (item_q.op == affx_pkg::OP_TRANS) ? v2_c : py_c;
        end
      end
    endcase
  end

  always_comb begin
    if (vert_q) begin
      if (state_q == S_MUL1) begin
        mul_a_c = TW'(row_q ? m_q[4] : m_q[1]);
        mul_b_c = v2_c;
      end else begin
        mul_a_c = TW'(row_q ? m_q[3] : m_q[0]);
        mul_b_c = v1_c;
      end
      add_c = TW'(row_q ? m_q[5] : m_q[2]);
    end else begin
      mul_a_c = (state_q == S_MUL1) ? t1_c : t0_c;
      mul_b_c = TW'((state_q == S_MUL1) ? m_q[3] : m_q[0]);
      add_c   = (col_q == 2'd2) ? t2_c : '0;
    end
  end

  assign prod_c = mul_a_c * mul_b_c;
  assign sum_c  = SW'(acc_q) + SW'(prod_q) + HALF_S;
  assign full_c = (sum_c >>> FRAC_BITS) + SW'(add_c);

  always_comb begin
    clip_c = 1'b0;
    res_c  = full_c[31:0];
    if (full_c > MAX_S) begin
      clip_c = 1'b1;
      res_c  = MAX_S[31:0];
    end else if (full_c < MIN_S) begin
      clip_c = 1'b1;
      res_c  = MIN_S[31:0];
    end
  end

  assign z0_c    = ZW'($signed(fq_i.item.ang)) <<< SHIFT_IN;
  assign zmag0_c = z0_c[ZW-1] ? ZW'(-z0_c) : ZW'(z0_c);
  assign zt_c    = zsgn_q ? -$signed(zmag_q) : $signed(zmag_q);
  assign atan_c  = ZW'(affx_pkg::atan_deg(it_q));
  assign xs_c    = x_q >>> it_q;
  assign ys_c    = y_q >>> it_q;
  assign xf_c    = neg_q ? -x_q : x_q;
  assign yf_c    = neg_q ? -y_q : y_q;

  assign pop_o  = (state_q == S_IDLE) && fq_i.valid;
  assign free_c = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      m_q[0]      <= ONE_M;
      m_q[1]      <= '0;
      m_q[2]      <= '0;
      m_q[3]      <= '0;
      m_q[4]      <= ONE_M;
      m_q[5]      <= '0;
      r0_q        <= '0;
      xo_q        <= '0;
      mat_clip_q  <= 1'b0;
      vclip_q     <= 1'b0;
      stg_q       <= STG_PRE;
      col_q       <= '0;
      row_q       <= 1'b0;
      vert_q      <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      zmag_q      <= '0;
      fk_q        <= '0;
      zsgn_q      <= 1'b0;
      neg_q       <= 1'b0;
      red_q       <= '0;
      z_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      it_q        <= '0;
      sin_q       <= '0;
      cos_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      x_out_q     <= '0;
      y_out_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (fq_i.valid) begin
            item_q <= fq_i.item;
            row_q  <= 1'b0;
            col_q  <= '0;
            vert_q <= 1'b0;
            case (fq_i.item.op)
              affx_pkg::OP_IDENT: begin
                m_q[0]     <= ONE_M;
                m_q[1]     <= '0;
                m_q[2]     <= '0;
                m_q[3]     <= '0;
                m_q[4]     <= ONE_M;
                m_q[5]     <= '0;
                mat_clip_q <= 1'b0;
              end
              affx_pkg::OP_TRANS: begin
                stg_q   <= STG_POST;
                state_q <= S_MUL0;
              end
              affx_pkg::OP_SCALE: begin
                stg_q   <= STG_PRE;
                state_q <= S_MUL0;
              end
              affx_pkg::OP_ROT: begin
                zsgn_q  <= z0_c[ZW-1];
                zmag_q  <= zmag0_c;
                fk_q    <= FK0;
                red_q   <= RW'(RED - 1);
                state_q <= S_CRM;
              end
              affx_pkg::OP_VERT: begin
                vert_q  <= 1'b1;
                state_q <= S_MUL0;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_CRM: begin
          if (zmag_q >= fk_q) begin
            zmag_q <= zmag_q - fk_q;
          end
          fk_q  <= fk_q >> 1;
          red_q <= red_q - 1'b1;
          if (red_q == '0) begin
            state_q <= S_CRW;
          end
        end
        S_CRW: begin
          if (zt_c >= HALF_Z) begin
            z_q <= zt_c - FULL_Z;
          end else if (zt_c < -HALF_Z) begin
            z_q <= zt_c + FULL_Z;
          end else begin
            z_q <= zt_c;
          end
          state_q <= S_CRF;
        end
        S_CRF: begin
          if (z_q > QUART_Z) begin
            z_q   <= z_q - HALF_Z;
            neg_q <= 1'b1;
          end else if (z_q < -QUART_Z) begin
            z_q   <= z_q + HALF_Z;
            neg_q <= 1'b1;
          end else begin
            neg_q <= 1'b0;
          end
          x_q     <= X0;
          y_q     <= '0;
          it_q    <= '0;
          state_q <= S_CRI;
        end
        S_CRI: begin
          if (!z_q[ZW-1]) begin
            x_q <= x_q - ys_c;
            y_q <= y_q + xs_c;
            z_q <= z_q - atan_c;
          end else begin
            x_q <= x_q + ys_c;
            y_q <= y_q - xs_c;
            z_q <= z_q + atan_c;
          end
          it_q <= it_q + 1'b1;
          if (it_q == IT_LAST) begin
            state_q <= S_CRE;
          end
        end
        S_CRE: begin
          cos_q   <= TW'((xf_c + RND_X) >>> SH);
          sin_q   <= TW'((yf_c + RND_X) >>> SH);
          stg_q   <= STG_PRE;
          state_q <= S_MUL0;
        end
        S_MUL0: begin
          prod_q  <= prod_c;
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          acc_q   <= prod_q;
          prod_q  <= prod_c;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (vert_q) begin
            if (!row_q) begin
              xo_q    <= res_c;
              vclip_q <= clip_c;
              row_q   <= 1'b1;
              state_q <= S_MUL0;
            end else begin
              r0_q    <= res_c;
              vclip_q <= vclip_q | clip_c;
              state_q <= S_OUT;
            end
          end else begin
            mat_clip_q <= mat_clip_q | clip_c;
            if (!row_q) begin
              r0_q    <= res_c;
              row_q   <= 1'b1;
              state_q <= S_MUL0;
            end else begin
              m_q[0] <= m_q[1];
              m_q[1] <= m_q[2];
              m_q[2] <= r0_q;
              m_q[3] <= m_q[4];
              m_q[4] <= m_q[5];
              m_q[5] <= res_c;
              row_q  <= 1'b0;
              if (col_q == 2'd2) begin
                col_q <= '0;
                if (stg_q == STG_POST) begin
                  state_q <= S_IDLE;
                end else begin
                  stg_q   <= stg_q + 1'b1;
                  state_q <= S_MUL0;
                end
              end else begin
                col_q   <= col_q + 1'b1;
                state_q <= S_MUL0;
              end
            end
          end
        end
        S_OUT: begin
          if (free_c) begin
            out_valid_q <= 1'b1;
            x_out_q     <= xo_q;
            y_out_q     <= r0_q;
            sat_q       <= vclip_q | mat_clip_q;
            last_q      <= item_q.last;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign saturated_o = sat_q;
  assign last_out_o  = last_q;

  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && fq_i.item.op == affx_pkg::OP_IDENT) |=>
      (m_q[0] == ONE_M && m_q[4] == ONE_M && !mat_clip_q))
    else $error("identity command did not restore the matrix");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result beat raised outside the output step");

  a_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRI) |-> (it_q <= IT_LAST))
    else $error("CORDIC step count overran");

endmodule

// File: test/affx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Affine transform engine checker
// Follows both channels, keeps its own copy of the composite matrix, works
// out each vertex beat and compares it with what the engine returns.
// ----------------------------------------------------------------------------
module affx_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] first_value_i,
  input  logic signed [31:0] second_value_i,
  input  logic signed [31:0] pivot_x_i,
  input  logic signed [31:0] pivot_y_i,
  input  logic signed [25:0] angle_deg_i,
  input  logic               last_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] x_out_i,
  input  logic signed [31:0] y_out_i,
  input  logic               saturated_i,
  input  logic               last_out_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 vertex_count_o
);

  localparam int FB = 16;
  localparam int STEPS = 16;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
    logic               last;
  } point_t;

  longint mat [6];
  bit     mat_sat;
  point_t point_q[$];

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint dot_round(longint t1, longint m1, longint t2, longint m2,
                                       longint add, ref bit sat);
    longint p1, p2, lo, sum;
    longint mask;
    mask = (64'sd1 << FB) - 1;
    p1 = t1 * m1;
    p2 = t2 * m2;
    lo = (p1 & mask) + (p2 & mask) + (64'sd1 << (FB - 1));
    sum = shr(p1, FB) + shr(p2, FB) + (lo >>> FB) + add;
    return clamp32(sum, sat);
  endfunction

  task automatic premultiply(longint t00, longint t01, longint t02,
                             longint t10, longint t11, longint t12);
    longint r [6];
    for (int c = 0; c < 3; c++) begin
      r[c]     = dot_round(t00, mat[c], t01, mat[3+c], (c == 2) ? t02 : 0, mat_sat);
      r[3 + c] = dot_round(t10, mat[c], t11, mat[3+c], (c == 2) ? t12 : 0, mat_sat);
    end
    for (int c = 0; c < 6; c++) mat[c] = r[c];
  endtask

  task automatic shift_by(longint tx, longint ty);
    premultiply(64'sd1 << FB, 0, tx, 0, 64'sd1 << FB, ty);
  endtask

  task automatic sine_cosine(longint ang, output longint s, output longint co);
    longint z, x, y, xs, ys;
    bit     flip;
    z = ang * (64'sd1 << (24 - FB));
    x = 64'sd652032875 + (64'sd434688583 >>> (2 * STEPS));
    y = 0;
    flip = 0;
    z = z % affx_pkg::FULL_DEG;
    if (z >= affx_pkg::HALF_DEG) z -= affx_pkg::FULL_DEG;
    if (z < -affx_pkg::HALF_DEG) z += affx_pkg::FULL_DEG;
    if (z > affx_pkg::QUARTER_DEG) begin
      z -= affx_pkg::HALF_DEG;
      flip = 1;
    end else if (z < -affx_pkg::QUARTER_DEG) begin
      z += affx_pkg::HALF_DEG;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(affx_pkg::atan_deg(5'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(affx_pkg::atan_deg(5'(i)));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    co = shr(x + (64'sd1 << (29 - FB)), 30 - FB);
    s  = shr(y + (64'sd1 << (29 - FB)), 30 - FB);
  endtask

  task automatic clear_matrix();
    foreach (mat[i]) mat[i] = 0;
    mat[0] = 64'sd1 << FB;
    mat[4] = 64'sd1 << FB;
    mat_sat = 0;
  endtask

  task automatic apply_beat();
    longint v1, v2, px, py, s, c;
    bit     sat;
    point_t p;
    v1 = first_value_i;
    v2 = second_value_i;
    px = pivot_x_i;
    py = pivot_y_i;
    case (kind_i)
      affx_pkg::KIND_IDENT: clear_matrix();
      affx_pkg::KIND_TRANS: shift_by(v1, v2);
      affx_pkg::KIND_SCALE: begin
        shift_by(-px, -py);
        premultiply(v1, 0, 0, 0, v2, 0);
        shift_by(px, py);
      end
      affx_pkg::KIND_ROT: begin
        sine_cosine(longint'(angle_deg_i), s, c);
        shift_by(-px, -py);
        premultiply(c, -s, 0, s, c, 0);
        shift_by(px, py);
      end
      affx_pkg::KIND_VERT: begin
        sat = 0;
        p.x = 32'(dot_round(mat[0], v1, mat[1], v2, mat[2], sat));
        p.y = 32'(dot_round(mat[3], v1, mat[4], v2, mat[5], sat));
        p.sat = sat | mat_sat;
        p.last = last_in_i;
        point_q.push_back(p);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    vertex_count_o = 0;
    clear_matrix();
  end

  assign pending_o = point_q.size();

  always @(posedge clk_i) begin
    point_t p;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        vertex_count_o++;
        if (point_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          p = point_q.pop_front();
          if (x_out_i !== p.x) report("x", x_out_i, p.x);
          if (y_out_i !== p.y) report("y", y_out_i, p.y);
          if (saturated_i !== p.sat) report("saturated", saturated_i, p.sat);
          if (last_out_i !== p.last) report("last", last_out_i, p.last);
        end
      end
      if (in_valid_i && !in_stall_i) apply_beat();
    end
  end
endmodule

// File: test/affine_transform_2d_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Affine transform engine testbench
// Drives command and vertex beats under varying idle and stall patterns,
// including a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module affine_transform_2d_engine_core_tb;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [2:0]         kind_i = 0;
  logic signed [31:0] first_value_i = 0;
  logic signed [31:0] second_value_i = 0;
  logic signed [31:0] pivot_x_i = 0;
  logic signed [31:0] pivot_y_i = 0;
  logic signed [25:0] angle_deg_i = 0;
  logic               last_in_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [31:0] x_out_o;
  logic signed [31:0] y_out_o;
  logic               saturated_o;
  logic               last_out_o;

  int fail_count, pending, vertex_count;
  int idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  int beats_sent = 0;
  longint cycle_count = 0;

  always #4 clk_i = ~clk_i;

  affine_transform_2d_engine_core i_dut (.*);

  affx_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .first_value_i,
    .second_value_i, .pivot_x_i, .pivot_y_i, .angle_deg_i, .last_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .x_out_i(x_out_o), .y_out_i(y_out_o),
    .saturated_i(saturated_o), .last_out_i(last_out_o),
    .fail_count_o(fail_count), .pending_o(pending), .vertex_count_o(vertex_count)
  );

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  // drive one beat and wait until it is taken
  task automatic send(logic [2:0] kind, logic signed [31:0] v1, logic signed [31:0] v2,
                      logic signed [31:0] px, logic signed [31:0] py,
                      logic signed [25:0] ang, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    first_value_i <= v1;
    second_value_i <= v2;
    pivot_x_i <= px;
    pivot_y_i <= py;
    angle_deg_i <= ang;
    last_in_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_random();
    int r;
    logic [2:0] k;
    logic signed [25:0] ang;
    r = $urandom_range(99);
    if (r < 55) k = affx_pkg::KIND_VERT;
    else if (r < 63) k = affx_pkg::KIND_IDENT;
    else if (r < 75) k = affx_pkg::KIND_TRANS;
    else if (r < 85) k = affx_pkg::KIND_SCALE;
    else if (r < 97) k = affx_pkg::KIND_ROT;
    else k = 3'($urandom_range(7, 5));
    ang = ($urandom_range(3) == 0) ? 26'($urandom)
        : 26'($signed($urandom_range(720 << 16)) - (360 << 16));
    if (k == affx_pkg::KIND_SCALE && $urandom_range(1))
      send(k, $signed($urandom_range(3 << 16)) - (1 << 16),
           $signed($urandom_range(3 << 16)) - (1 << 16), rand_value(), rand_value(),
           ang, $urandom_range(1));
    else
      send(k, rand_value(), rand_value(), rand_value(), rand_value(), ang,
           $urandom_range(1));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: every kind, field extremes, angle folding and wraparound
    send(affx_pkg::KIND_VERT, 32'sh00010000, 32'sh00020000, 0, 0, 0, 1'b1);
    send(affx_pkg::KIND_VERT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 0, 1'b0);
    send(affx_pkg::KIND_TRANS, 32'sh00030000, -32'sh00020000, 0, 0, 0, 0);
    send(affx_pkg::KIND_VERT, 32'sh00008000, -32'sh00008000, 0, 0, 0, 1'b1);
    send(affx_pkg::KIND_ROT, 0, 0, 32'sh00010000, 32'sh00010000, 26'sd90 <<< 16, 0);
    send(affx_pkg::KIND_VERT, 32'sh00020000, 0, 0, 0, 0, 1'b0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, 26'sh2000000, 0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, 26'sh1ffffff, 0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, 26'sd180 <<< 16, 0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, -(26'sd180 <<< 16), 0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, 26'sd23592960, 0);
    send(affx_pkg::KIND_ROT, 0, 0, 0, 0, -26'sd23592960, 0);
    send(affx_pkg::KIND_VERT, 32'sh00050000, 32'sh00070000, 0, 0, 0, 1'b1);
    send(affx_pkg::KIND_SCALE, 32'sh00020000, 32'sh00008000, 32'sh00010000,
         -32'sh00010000, 0, 0);
    send(affx_pkg::KIND_VERT, 32'sh00010000, 32'sh00010000, 0, 0, 0, 1'b0);
    send(affx_pkg::KIND_SCALE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 0, 0);
    send(affx_pkg::KIND_VERT, 0, 0, 0, 0, 0, 1'b1);
    send(3'd5, 1, 1, 1, 1, 1, 1);
    send(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 26'h3ffffff, 1);
    send(affx_pkg::KIND_IDENT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         26'h3ffffff, 1);
    send(affx_pkg::KIND_VERT, 32'hffffffff, 0, 0, 0, 0, 1'b0);
    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        3: begin idle_pct = 33; stall_pct = 33; end
        4: begin idle_pct = 0;  stall_pct = 0;  hold_cycles = 300; end
      endcase
      for (int n = 0; n < 80; n++) send_random();
    end
    in_valid_i <= 1'b0;
    stall_pct = 20;
    while (pending > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d beats in, %0d vertex beats out, across idle and stall phases",
             beats_sent, vertex_count);
    $display("included a long output hold-off with the input backed up");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
